@@ sv/stpq_pkg.sv @@
`timescale 1ns / 1ps

package stpq_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int HND_W    = 8;
    localparam int PRI_W    = 8;
    localparam int TAG_W    = 4;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;
    localparam int TAG_CNT  = 16;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TAKE   = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

@@ sv/stpq_dp.sv @@
`timescale 1ns / 1ps

module stpq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stpq_pkg::cmd_t                cmd,
    input  logic [stpq_pkg::OP_W-1:0]     operation,
    input  logic [stpq_pkg::HND_W-1:0]    handler_id,
    input  logic [stpq_pkg::PRI_W-1:0]    priority_req,
    input  logic [stpq_pkg::TAG_W-1:0]    task_tag,
    output logic [stpq_pkg::STAT_W-1:0]   status,
    output logic [stpq_pkg::HND_W-1:0]    out_handler,
    output logic [stpq_pkg::TAG_W-1:0]    out_tag,
    output logic [stpq_pkg::CNT_W-1:0]    occupancy
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W = (IDX_W + 1 > stpq_pkg::CNT_W) ? IDX_W + 1 : stpq_pkg::CNT_W;
    localparam int MAX_ENTRIES = (QUEUE_DEPTH < stpq_pkg::TAG_CNT) ?
                                 QUEUE_DEPTH : stpq_pkg::TAG_CNT;

    // latched item
    stpq_pkg::op_t               op_reg;
    logic [stpq_pkg::HND_W-1:0]  hnd_in_reg;
    logic [stpq_pkg::PRI_W-1:0]  pri_in_reg;
    logic [stpq_pkg::TAG_W-1:0]  tag_in_reg;

    // slot array, kept sorted by priority
    logic [stpq_pkg::PRI_W-1:0]  pri_reg  [QUEUE_DEPTH];
    logic [stpq_pkg::PRI_W-1:0]  pri_next [QUEUE_DEPTH];
    logic [stpq_pkg::HND_W-1:0]  hnd_reg  [QUEUE_DEPTH];
    logic [stpq_pkg::HND_W-1:0]  hnd_next [QUEUE_DEPTH];
    logic [stpq_pkg::TAG_W-1:0]  tag_reg  [QUEUE_DEPTH];
    logic [stpq_pkg::TAG_W-1:0]  tag_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      run_reg;
    logic [QUEUE_DEPTH-1:0]      run_next;

    logic [stpq_pkg::CNT_W-1:0]   count_reg;
    logic [stpq_pkg::CNT_W-1:0]   count_next;
    logic [stpq_pkg::TAG_CNT-1:0] tag_use_reg;
    logic [stpq_pkg::TAG_CNT-1:0] tag_use_next;

    // result registers
    stpq_pkg::status_t           status_reg;
    stpq_pkg::status_t           status_next;
    logic [stpq_pkg::HND_W-1:0]  ohnd_reg;
    logic [stpq_pkg::HND_W-1:0]  ohnd_next;
    logic [stpq_pkg::TAG_W-1:0]  otag_reg;
    logic [stpq_pkg::TAG_W-1:0]  otag_next;

    // search results
    logic [CMP_W-1:0]            cnt_ext;
    logic [stpq_pkg::TAG_W-1:0]  free_tag;
    logic                        free_found;
    logic                        full;
    logic [QUEUE_DEPTH-1:0]      mark;
    logic [QUEUE_DEPTH-1:0]      first;
    logic [QUEUE_DEPTH-1:0]      match;
    logic [IDX_W-1:0]            match_pos;
    logic                        found;
    logic [QUEUE_DEPTH-1:0]      rm;

    assign cnt_ext = CMP_W'(count_reg);

    // lowest free tag
    always_comb
    begin
        free_tag   = '0;
        free_found = 1'b0;
        for (int i = stpq_pkg::TAG_CNT - 1; i >= 0; i--)
        begin
            if (!tag_use_reg[i])
            begin
                free_tag   = stpq_pkg::TAG_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign full = (cnt_ext >= CMP_W'(QUEUE_DEPTH)) || !free_found;

    // insert region: slots from the insert point up to the count move down one
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (CMP_W'(i) < cnt_ext)
            begin
                mark[i] = pri_reg[i] > pri_in_reg;
            end
            else
            begin
                mark[i] = (CMP_W'(i) == cnt_ext);
            end
        end
    end

    assign first = mark & ~(mark << 1);

    // finish search: tags of queued entries are unique, so match is one-hot
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match[i] = (CMP_W'(i) < cnt_ext) && (tag_reg[i] == tag_in_reg);
            if (match[i])
            begin
                match_pos = match_pos | IDX_W'(i);
            end
        end
        found = |match;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            rm[i] = found && (CMP_W'(i) < cnt_ext) && (CMP_W'(i) >= CMP_W'(match_pos));
        end
    end

    // next state of slots, counters and result
    always_comb
    begin
        pri_next     = pri_reg;
        hnd_next     = hnd_reg;
        tag_next     = tag_reg;
        run_next     = run_reg;
        count_next   = count_reg;
        tag_use_next = tag_use_reg;
        status_next  = status_reg;
        ohnd_next    = ohnd_reg;
        otag_next    = otag_reg;
        if (cmd.exec)
        begin
            status_next = stpq_pkg::ST_OK;
            ohnd_next   = '0;
            otag_next   = '0;
            case (op_reg)
                stpq_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = stpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < QUEUE_DEPTH; i++)
                        begin
                            if (first[i])
                            begin
                                pri_next[i] = pri_in_reg;
                                hnd_next[i] = hnd_in_reg;
                                tag_next[i] = free_tag;
                                run_next[i] = 1'b0;
                            end
                            else if (mark[i] && i > 0)
                            begin
                                pri_next[i] = pri_reg[i-1];
                                hnd_next[i] = hnd_reg[i-1];
                                tag_next[i] = tag_reg[i-1];
                                run_next[i] = run_reg[i-1];
                            end
                        end
                        count_next             = count_reg + 1'b1;
                        tag_use_next[free_tag] = 1'b1;
                        otag_next              = free_tag;
                    end
                end
                stpq_pkg::OP_TAKE:
                begin
                    if (count_reg != '0 && !run_reg[0])
                    begin
                        run_next[0] = 1'b1;
                        ohnd_next   = hnd_reg[0];
                        otag_next   = tag_reg[0];
                    end
                    else
                    begin
                        status_next = stpq_pkg::ST_EMPTY;
                    end
                end
                stpq_pkg::OP_FINISH:
                begin
                    if (!found)
                    begin
                        status_next = stpq_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        begin
                            if (rm[i])
                            begin
                                pri_next[i] = pri_reg[i+1];
                                hnd_next[i] = hnd_reg[i+1];
                                tag_next[i] = tag_reg[i+1];
                                run_next[i] = run_reg[i+1];
                            end
                        end
                        if (rm[QUEUE_DEPTH-1])
                        begin
                            run_next[QUEUE_DEPTH-1] = 1'b0;
                        end
                        count_next               = count_reg - 1'b1;
                        tag_use_next[tag_in_reg] = 1'b0;
                    end
                end
                default:
                begin
                    status_next = stpq_pkg::ST_OK;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            count_reg   <= '0;
            tag_use_reg <= '0;
        end
        else
        begin
            run_reg     <= run_next;
            count_reg   <= count_next;
            tag_use_reg <= tag_use_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= stpq_pkg::op_t'(operation);
            hnd_in_reg <= handler_id;
            pri_in_reg <= priority_req;
            tag_in_reg <= task_tag;
        end
        pri_reg    <= pri_next;
        hnd_reg    <= hnd_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        ohnd_reg   <= ohnd_next;
        otag_reg   <= otag_next;
    end

    assign status      = status_reg;
    assign out_handler = ohnd_reg;
    assign out_tag     = otag_reg;
    assign occupancy   = count_reg;

    // count never passes the slot or tag limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(MAX_ENTRIES))
        else $error("entry count beyond limit");

    // one tag in use per queued entry
    a_tag_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tag_use_reg) == int'(count_reg))
        else $error("tag map out of step with entry count");

    // a successful take leaves the head running
    a_take_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && op_reg == stpq_pkg::OP_TAKE && count_reg != '0 |=> run_reg[0])
        else $error("head not running after take");

    // no running mark while the queue is empty
    a_run_tail: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> run_reg == '0)
        else $error("running mark on empty queue");

endmodule

@@ sv/stpq_ctrl.sv @@
`timescale 1ns / 1ps

module stpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output stpq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // sequencing: take item, update queue, present result
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // an accepted item shows its result once the update state has passed
    a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid ##1 out_valid)
        else $error("result not presented on time");

    // no new item while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // the queue is updated once per item
    a_one_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec && out_valid)
        else $error("update not followed by result");

endmodule

@@ sv/stable_priority_task_queue_core.sv @@
`timescale 1ns / 1ps

// channel  handshake            payload
// in       in_valid / in_stall  operation, handler_id, priority_req, task_tag
// out      out_valid/ out_stall status, out_handler, out_tag, occupancy
//
// one item passes three steps: accept, queue update, result presented.
// the queue update shifts the sorted slot array for an insert or finish; a take only marks the head running.
// the next item is taken the cycle after the result leaves.
// rst_n clears the count, tag map and running marks at once; no clearing pass.
// in_stall stays high from accept until the result is taken.

module stable_priority_task_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [stpq_pkg::OP_W-1:0]     operation,
    input  logic [stpq_pkg::HND_W-1:0]    handler_id,
    input  logic [stpq_pkg::PRI_W-1:0]    priority_req,
    input  logic [stpq_pkg::TAG_W-1:0]    task_tag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stpq_pkg::STAT_W-1:0]   status,
    output logic [stpq_pkg::HND_W-1:0]    out_handler,
    output logic [stpq_pkg::TAG_W-1:0]    out_tag,
    output logic [stpq_pkg::CNT_W-1:0]    occupancy
);

    stpq_pkg::cmd_t cmd;

    // sequencer
    stpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // sorted slot array
    stpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .handler_id   (handler_id),
        .priority_req (priority_req),
        .task_tag     (task_tag),
        .status       (status),
        .out_handler  (out_handler),
        .out_tag      (out_tag),
        .occupancy    (occupancy)
    );

endmodule
